[hdl/integer_set_table_top_assert.svh]
// Assertion macros used by the integer set table top level.
`ifndef INTEGER_SET_TABLE_TOP_ASSERT_SVH
`define INTEGER_SET_TABLE_TOP_ASSERT_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define IST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define IST_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define IST_ASSERT(lbl, prop, msg)
`define IST_NEVER(lbl, expr, msg)
`endif

`endif

[hdl/ist_pkg.sv]
// Package with the shared types and constants of the integer set table.
`timescale 1ns / 1ps
package ist_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_LOOKUP = 3'd2,
    ACT_MAXMIN = 3'd3,
    ACT_CLEAR  = 3'd4
  } ist_action_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_SHIFT,
    CELL_WRITE
  } ist_cell_op_e;

  typedef struct packed {
    ist_cell_op_e        op;
    logic [WORD_W-1:0]   data;
  } ist_cell_ctl_t;

endpackage

[hdl/ist_cell.sv]
// One storage cell of the set ring: holds one entry and passes it to its neighbor.
`timescale 1ns / 1ps
module ist_cell
  import ist_pkg::*;
#(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic                clk_i,
  input  ist_cell_ctl_t       ctl_i,
  input  logic [IDX_W-1:0]    sel_i,
  input  logic [WORD_W-1:0]   next_i,
  output logic [WORD_W-1:0]   entry_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [WORD_W-1:0] entry_q;
  logic [WORD_W-1:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      CELL_ROTATE: entry_d = next_i;
      // Removal closes the gap: every cell at or above the removed slot
      // takes the entry of its upper neighbor.
      CELL_SHIFT: begin
        if (MyIdx >= sel_i) begin
          entry_d = next_i;
        end
      end
      CELL_WRITE: begin
        if (MyIdx == sel_i) begin
          entry_d = ctl_i.data;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[hdl/integer_set_table_top.sv]
// Top level of the integer set table: control sequencer and the ring of entry cells.
//
//  Channel   Direction  Handshake             Payload
//  command   in         start, busy           action_i, value_i
//  result    out        done_o (one cycle)    ok_o, position_o, largest_o, smallest_o, fill_o
//
// Insert, remove, lookup and max-min each rotate the whole ring once, so that
// every entry passes the head cell; a transaction of these kinds keeps busy high
// through the scan and finish states, and its result is registered out of the
// finish state. Clear and the unused action codes finish at once: the result strobes
// in the next cycle and busy stays low. The asynchronous reset empties the set;
// the entry cells themselves are not reset. The receiver cannot stall, so every
// result is presented for exactly one cycle.
`timescale 1ns / 1ps
module integer_set_table_top
  import ist_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               action_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic                     done_o,
  output logic                     ok_o,
  output logic [5:0]               position_o,
  output logic signed [WORD_W-1:0] largest_o,
  output logic signed [WORD_W-1:0] smallest_o,
  output logic [6:0]               fill_o
);

`include "integer_set_table_top_assert.svh"

  // Index width addresses one cell; count width can also hold CAPACITY itself.
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [2:0]        act_q, act_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  step_q, step_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  at_q, at_d;
  logic signed [WORD_W-1:0] max_q, max_d;
  logic signed [WORD_W-1:0] min_q, min_d;

  logic              done_q, done_d;
  logic              ok_q, ok_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [WORD_W-1:0] big_q, big_d;
  logic [WORD_W-1:0] small_q, small_d;
  logic [CNT_W-1:0]  fill_q, fill_d;

  ist_cell_ctl_t     cell_ctl;
  logic [IDX_W-1:0]  cell_sel;
  logic [WORD_W-1:0] cell_q [CAPACITY];

  logic              accept;
  logic              step_valid;
  logic signed [WORD_W-1:0] head;
  logic              has_room;

  logic [IDX_W+5:0]  pos_wide;
  logic [CNT_W+6:0]  fill_wide;

  assign accept     = start && !busy;
  assign head       = cell_q[0];
  assign step_valid = CNT_W'(step_q) < count_q;
  assign has_room   = count_q < CNT_W'(CAPACITY);

  // The ring: cell i takes from cell i+1 and the last cell takes from the head,
  // so after k rotations the head holds the entry that started at slot k.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ist_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .sel_i   (cell_sel),
      .next_i  (cell_q[(g + 1) % CAPACITY]),
      .entry_o (cell_q[g])
    );
  end

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    val_d    = val_q;
    count_d  = count_q;
    step_d   = step_q;
    found_d  = found_q;
    at_d     = at_q;
    max_d    = max_q;
    min_d    = min_q;
    done_d   = 1'b0;
    ok_d     = ok_q;
    pos_d    = pos_q;
    big_d    = big_q;
    small_d  = small_q;
    fill_d   = fill_q;
    cell_ctl = '{op: CELL_HOLD, data: val_q};
    cell_sel = at_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d   = action_i;
          val_d   = value_i;
          step_d  = '0;
          found_d = 1'b0;
          at_d    = '0;
          if (action_i == ACT_INSERT || action_i == ACT_REMOVE ||
              action_i == ACT_LOOKUP || action_i == ACT_MAXMIN) begin
            state_d = ST_SCAN;
          end else begin
            // Clear and unused codes complete without touching the ring.
            if (action_i == ACT_CLEAR) begin
              count_d = '0;
            end
            done_d  = 1'b1;
            ok_d    = (action_i == ACT_CLEAR);
            pos_d   = '0;
            big_d   = '0;
            small_d = '0;
            fill_d  = (action_i == ACT_CLEAR) ? '0 : count_q;
          end
        end
      end

      ST_SCAN: begin
        cell_ctl.op = CELL_ROTATE;
        if (step_valid) begin
          if (!found_q && (head == val_q)) begin
            found_d = 1'b1;
            at_d    = step_q;
          end
          if (step_q == '0) begin
            max_d = head;
            min_d = head;
          end else begin
            if (head > max_q) begin
              max_d = head;
            end
            if (head < min_q) begin
              min_d = head;
            end
          end
        end
        step_d = step_q + 1'b1;
        if (step_q == IDX_W'(CAPACITY - 1)) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        ok_d    = 1'b0;
        pos_d   = '0;
        big_d   = '0;
        small_d = '0;
        case (act_q)
          ACT_INSERT: begin
            if (!found_q && has_room) begin
              cell_ctl.op = CELL_WRITE;
              cell_sel    = count_q[IDX_W-1:0];
              count_d     = count_q + 1'b1;
              ok_d        = 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (found_q) begin
              cell_ctl.op = CELL_SHIFT;
              count_d     = count_q - 1'b1;
              ok_d        = 1'b1;
            end
          end
          ACT_LOOKUP: begin
            ok_d  = found_q;
            pos_d = found_q ? at_q : '0;
          end
          ACT_MAXMIN: begin
            if (count_q != '0) begin
              ok_d    = 1'b1;
              big_d   = max_q;
              small_d = min_q;
            end
          end
          default: ok_d = 1'b0;
        endcase
        fill_d = count_d;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    val_q   <= val_d;
    step_q  <= step_d;
    found_q <= found_d;
    at_q    <= at_d;
    max_q   <= max_d;
    min_q   <= min_d;
    ok_q    <= ok_d;
    pos_q   <= pos_d;
    big_q   <= big_d;
    small_q <= small_d;
    fill_q  <= fill_d;
  end

  // Position and fill are fitted to their port widths whatever CAPACITY is.
  assign pos_wide  = {6'b0, pos_q};
  assign fill_wide = {7'b0, fill_q};

  assign busy       = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign ok_o       = ok_q;
  assign position_o = pos_wide[5:0];
  assign largest_o  = big_q;
  assign smallest_o = small_q;
  assign fill_o     = fill_wide[6:0];

  `IST_NEVER(a_count_bound, count_q > CNT_W'(CAPACITY), "entry count exceeds capacity")
  `IST_ASSERT(a_accept_progress, accept |=> (done_o || busy), "accepted transaction made no progress")
  `IST_ASSERT(a_found_in_range, (state_q == ST_FINISH && found_q) |-> (CNT_W'(at_q) < count_q), "match position beyond entry count")
  `IST_ASSERT(a_remove_count, (done_o && ok_o && act_q == ACT_REMOVE) |-> (count_q == $past(count_q) - 1'b1), "successful remove did not shrink the set by one")
  `IST_ASSERT(a_maxmin_order, (done_o && ok_o && act_q == ACT_MAXMIN) |-> (largest_o >= smallest_o), "largest entry below smallest entry")

endmodule
